// ===== sv/si16dec_pkg.sv =====
// Shared types, character codes and digit split helper for the decimal text converter.
`timescale 1ns / 1ps
`default_nettype none

package si16dec_pkg;

	localparam int unsigned RUN_MAX = 6;

	localparam logic [5:0] CHAR_SPACE = 6'd32;
	localparam logic [5:0] CHAR_MINUS = 6'd45;
	localparam logic [5:0] CHAR_ZERO  = 6'd48;
	localparam logic [5:0] CHAR_NINE  = 6'd57;

	localparam logic [15:0] PLACE_10K = 16'd10000;
	localparam logic [15:0] PLACE_1K  = 16'd1000;
	localparam logic [15:0] PLACE_100 = 16'd100;
	localparam logic [15:0] PLACE_10  = 16'd10;

	typedef logic [3:0] dec_digit_t;
	typedef logic [5:0] char_t;
	typedef logic [2:0] char_idx_t;

	typedef struct packed {
		logic             neg;
		dec_digit_t [4:0] dg;
	} run_t;

	typedef struct packed {
		dec_digit_t  digit;
		logic [15:0] rem;
	} split_t;

	function automatic split_t split_digit(input logic [15:0] r, input logic [15:0] place);
		split_t      res;
		logic [19:0] prod;
		int          k;
		res.digit = '0;
		for (k = 1; k <= 9; k++) begin
			if (20'(r) >= 20'(k) * 20'(place)) begin
				res.digit = 4'(k);
			end
		end
		prod = 20'(res.digit) * 20'(place);
		res.rem = 16'(20'(r) - prod);
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== sv/si16dec_digits.sv =====
// Five-stage pipeline that splits a signed word into sign and five decimal digits.
`timescale 1ns / 1ps
`default_nettype none

module si16dec_digits
	import si16dec_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [15:0]  value,
	output logic              busy,
	output run_t              run,
	output logic              run_valid,
	input  wire logic         run_take
);

	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic        ld1, ld2, ld3, ld4, ld5;
	logic        neg_s1;
	logic [15:0] mag_s1;
	run_t        run_s2, run_s3, run_s4, run_s5;
	logic [13:0] rem_s2;
	logic [9:0]  rem_s3;
	logic [6:0]  rem_s4;
	split_t      spl2, spl3, spl4, spl5;

	assign ld5  = !valid_s5 || run_take;
	assign ld4  = !valid_s4 || ld5;
	assign ld3  = !valid_s3 || ld4;
	assign ld2  = !valid_s2 || ld3;
	assign ld1  = !valid_s1 || ld2;
	assign busy = !ld1;

	assign spl2 = split_digit(mag_s1, PLACE_10K);
	assign spl3 = split_digit({2'b0, rem_s2}, PLACE_1K);
	assign spl4 = split_digit({6'b0, rem_s3}, PLACE_100);
	assign spl5 = split_digit({9'b0, rem_s4}, PLACE_10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ld1) valid_s1 <= start;
			if (ld2) valid_s2 <= valid_s1;
			if (ld3) valid_s3 <= valid_s2;
			if (ld4) valid_s4 <= valid_s3;
			if (ld5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			neg_s1 <= value[15];
			mag_s1 <= value[15] ? (~value + 16'd1) : value;
		end
		if (ld2) begin
			run_s2 <= '{neg: neg_s1, dg: {spl2.digit, 16'h0000}};
			rem_s2 <= spl2.rem[13:0];
		end
		if (ld3) begin
			run_s3 <= '{neg: run_s2.neg, dg: {run_s2.dg[4], spl3.digit, 12'h000}};
			rem_s3 <= spl3.rem[9:0];
		end
		if (ld4) begin
			run_s4 <= '{neg: run_s3.neg, dg: {run_s3.dg[4:3], spl4.digit, 8'h00}};
			rem_s4 <= spl4.rem[6:0];
		end
		if (ld5) begin
			run_s5 <= '{neg: run_s4.neg, dg: {run_s4.dg[4:2], spl5.digit, spl5.rem[3:0]}};
		end
	end

	assign run       = run_s5;
	assign run_valid = valid_s5;

`ifndef SYNTHESIS
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && !run_take |=> valid_s5 && $stable(run_s5))
		else $error("Last digit stage changed while held.");
`endif

endmodule

`default_nettype wire

// ===== sv/si16dec_emit.sv =====
// Character sequencer that sends one decimal run a character per cycle.
`timescale 1ns / 1ps
`default_nettype none

module si16dec_emit
	import si16dec_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire run_t   run,
	input  wire logic   run_valid,
	output logic        run_take,
	output logic        strobe,
	output char_t       character,
	output char_idx_t   char_index,
	output logic        last
);

	logic       run_valid_q;
	char_idx_t  idx_q;
	char_idx_t  last_idx_q;
	char_t      chars_q [RUN_MAX];
	char_t      chars_d [RUN_MAX];
	char_idx_t  last_idx_d;
	dec_digit_t seq [5];
	logic [2:0] first;
	logic [3:0] p;
	logic       at_end;

	always_comb begin
		for (int j = 0; j < 5; j++) begin
			seq[j] = run.dg[4 - j];
		end
		if (run.dg[4] != '0) begin
			first = 3'd0;
		end else if (run.dg[3] != '0) begin
			first = 3'd1;
		end else if (run.dg[2] != '0) begin
			first = 3'd2;
		end else if (run.dg[1] != '0) begin
			first = 3'd3;
		end else begin
			first = 3'd4;
		end
		chars_d[0] = run.neg ? CHAR_MINUS : CHAR_SPACE;
		p = '0;
		for (int j = 0; j < 5; j++) begin
			p = 4'(first) + 4'(j);
			if (p <= 4'd4) begin
				chars_d[j + 1] = CHAR_ZERO + 6'(seq[p[2:0]]);
			end else begin
				chars_d[j + 1] = CHAR_ZERO;
			end
		end
		last_idx_d = 3'd5 - first;
	end

	assign at_end   = idx_q == last_idx_q;
	assign run_take = !run_valid_q || at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (run_take) begin
			run_valid_q <= run_valid;
			idx_q       <= '0;
		end else begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (run_take) begin
			chars_q    <= chars_d;
			last_idx_q <= last_idx_d;
		end
	end

	assign strobe     = run_valid_q;
	assign character  = chars_q[idx_q];
	assign char_index = idx_q;
	assign last       = at_end;

`ifndef SYNTHESIS
	a_sign_first: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && char_index == '0 |-> character == CHAR_MINUS || character == CHAR_SPACE)
		else $error("First character of a run is not a sign.");
	a_digits_after: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && char_index != '0 |-> character >= CHAR_ZERO && character <= CHAR_NINE)
		else $error("Character after the sign is not a digit.");
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && char_index == $past(char_index) + 3'd1)
		else $error("Run broke off before its last character.");
	a_new_run_starts: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe || char_index == '0)
		else $error("Run after a last character did not start at its sign.");
`endif

endmodule

`default_nettype wire

// ===== sv/signed_int16_to_decimal_ascii_top.sv =====
// Top level of the signed 16-bit to decimal ASCII text converter.
`timescale 1ns / 1ps
`default_nettype none

// A word is taken when start is high and busy is low. Each word yields a run of two to six
// characters: a sign (minus or space), then the magnitude in decimal without leading zeros,
// one character per cycle on strobe, with last on the final one; -32768 comes out as "-32768".
// The first character reaches the ports through a five-stage digit pipeline and the character
// register. A run goes out one character at a time on the single character port; words follow
// one another with no gap, and busy rises only while the pipeline is full behind a long run.
// The receiver cannot stall.
module signed_int16_to_decimal_ascii_top
	import si16dec_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] value,
	output logic             busy,
	output logic             strobe,
	output logic [5:0]       character,
	output logic [2:0]       char_index,
	output logic             last
);

	run_t run;
	logic run_valid;
	logic run_take;

	si16dec_digits u_digits (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.value     (value),
		.busy      (busy),
		.run       (run),
		.run_valid (run_valid),
		.run_take  (run_take)
	);

	si16dec_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.run        (run),
		.run_valid  (run_valid),
		.run_take   (run_take),
		.strobe     (strobe),
		.character  (character),
		.char_index (char_index),
		.last       (last)
	);

endmodule

`default_nettype wire
